// ===== src/cbd_pkg.sv =====
// Shared types, constants and helpers for the chunked body decoder.
`default_nettype none

package cbd_pkg;

  // Width of the chunk-size and bytes-left registers.
  localparam int SIZE_BITS = 32;
  // Width of the running decoded-length counter.
  localparam int LEN_BITS  = 32;

  // Decoder phases.
  localparam logic [2:0] PH_SIZE  = 3'd0;
  localparam logic [2:0] PH_DATA  = 3'd1;
  localparam logic [2:0] PH_TRAIL = 3'd2;
  localparam logic [2:0] PH_DONE  = 3'd3;
  localparam logic [2:0] PH_ERR   = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_BUSY = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_LF = 8'h0A;

  typedef struct packed {
    logic [2:0]           phase;
    logic [SIZE_BITS-1:0] chunk_size;
    logic [SIZE_BITS-1:0] bytes_left;
    logic                 hex_stopped;
    logic                 saw_cr;
    logic                 trailer_skipped;
    logic [LEN_BITS-1:0]  total_out;
  } cbd_state_t;

  typedef struct packed {
    logic [7:0]          data;
    logic                valid;
    logic [1:0]          status;
    logic [LEN_BITS-1:0] length;
  } cbd_result_t;

  localparam cbd_state_t CBD_STATE_RESET = '{phase: PH_SIZE, default: '0};

  // Bit 4 set means "not a hex digit"; otherwise bits 3:0 hold the value.
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] v;
    v = 5'h10;
    if (b >= "0" && b <= "9") begin
      v = {1'b0, 4'(b - "0")};
    end else if (b >= "a" && b <= "f") begin
      v = {1'b0, 4'(b - "a" + 8'd10)};
    end else if (b >= "A" && b <= "F") begin
      v = {1'b0, 4'(b - "A" + 8'd10)};
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== src/cbd_step.sv =====
// Next-state and result logic for one body byte.
`default_nettype none

module cbd_step (
  input  wire cbd_pkg::cbd_state_t  cur,
  input  wire logic [7:0]           in_byte,
  input  wire logic                 is_last,
  output cbd_pkg::cbd_state_t       nxt,
  output cbd_pkg::cbd_result_t      res
);
  import cbd_pkg::*;

  cbd_state_t           upd;
  logic [4:0]           hv;
  logic [SIZE_BITS-1:0] bl_dec;
  logic                 boundary;
  logic                 err_hit;

  assign hv     = hex_value(in_byte);
  assign bl_dec = cur.bytes_left - 1'b1;

  always_comb begin
    upd      = cur;
    boundary = 1'b0;
    err_hit  = 1'b0;
    res.data  = '0;
    res.valid = 1'b0;
    unique case (cur.phase)
      PH_SIZE: begin
        if (cur.saw_cr && in_byte == BYTE_LF) begin
          if (cur.chunk_size == '0) begin
            upd.phase = PH_DONE;
          end else begin
            upd.bytes_left = cur.chunk_size;
            upd.phase      = PH_DATA;
          end
          upd.saw_cr = 1'b0;
        end else begin
          if (!cur.hex_stopped) begin
            if (!hv[4]) begin
              // top nibble occupied: another digit would overflow
              if (|cur.chunk_size[SIZE_BITS-1 -: 4]) begin
                upd.phase = PH_ERR;
                err_hit   = 1'b1;
              end else begin
                upd.chunk_size = {cur.chunk_size[SIZE_BITS-5:0], hv[3:0]};
              end
            end else begin
              upd.hex_stopped = 1'b1;
            end
          end
          if (!err_hit) begin
            upd.saw_cr = (in_byte == BYTE_CR);
          end
        end
      end
      PH_DATA: begin
        res.data  = in_byte;
        res.valid = 1'b1;
        if (~&cur.total_out) begin
          upd.total_out = cur.total_out + 1'b1;
        end
        upd.bytes_left = bl_dec;
        if (bl_dec == '0) begin
          upd.phase           = PH_TRAIL;
          upd.trailer_skipped = 1'b0;
        end
      end
      PH_TRAIL: begin
        if (!cur.trailer_skipped) begin
          upd.trailer_skipped = 1'b1;
        end else begin
          upd.phase           = PH_SIZE;
          upd.chunk_size      = '0;
          upd.hex_stopped     = 1'b0;
          upd.saw_cr          = 1'b0;
          upd.trailer_skipped = 1'b0;
          boundary            = 1'b1;
        end
      end
      PH_DONE: begin
      end
      default: begin
        upd.phase = PH_ERR;
      end
    endcase

    if (upd.phase == PH_DONE || (is_last && boundary)) begin
      res.status = ST_DONE;
    end else if (upd.phase == PH_ERR || is_last) begin
      res.status = ST_ERR;
    end else begin
      res.status = ST_BUSY;
    end
    res.length = upd.total_out;

    nxt = is_last ? CBD_STATE_RESET : upd;
  end

endmodule

`default_nettype wire

// ===== src/chunked_body_decoder_core.sv =====
// Top level of the chunked transfer-coding body decoder.
// Usage:
//  - in_*  : one raw body byte per beat in in_tdata, in_tlast on the final
//            byte of a body. After that beat the decoder starts afresh.
//  - out_* : exactly one result beat per input beat, in order. tdata holds
//            the payload byte and the running decoded length; tuser holds
//            the payload-valid flag and the status (busy, done, error).
//  - Path: an accepted byte waits in the input register, then moves to the
//    result register. Throughput: one byte per cycle while out_tready is
//    high; the decode is a single short pass of logic between the two
//    registers, with the parse state updated as the byte moves across.
//  - Stalls: when the receiver holds out_tready low the result register
//    keeps its beat and the input register can still take one more byte;
//    in_tready drops only when both are full.
//  - Reset (rst_n low, synchronous): both stages empty, parse state back
//    to the start of a size line with all counts cleared.
//  - Chunk sizes wider than SIZE_BITS bits are reported as errors; the
//    decoded length saturates at all ones.
`default_nettype none

module chunked_body_decoder_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  input  wire logic        in_tlast,   // is_last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [7:0] out_byte, [39:8] decoded_length
  output logic [2:0]       out_tuser   // [0] out_valid, [2:1] status
);
  import cbd_pkg::*;

  // input register stage
  logic        s1_vld_r, s1_vld_nxt;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;

  // parse state, advanced as a byte moves from s1 to the result stage
  cbd_state_t  state_r, state_nxt;
  cbd_state_t  step_state;
  cbd_result_t step_res;

  // result register
  logic        out_vld_r, out_vld_nxt;
  cbd_result_t out_res_r;

  logic s2_load;
  logic s1_load;

  assign s2_load   = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || s2_load;
  assign s1_load   = in_tvalid && in_tready;

  cbd_step u_step (
    .cur     (state_r),
    .in_byte (s1_byte_r),
    .is_last (s1_last_r),
    .nxt     (step_state),
    .res     (step_res)
  );

  always_comb begin
    s1_vld_nxt = s1_load || (s1_vld_r && !s2_load);
    out_vld_nxt = s2_load || (out_vld_r && !out_tready);
    state_nxt   = s2_load ? step_state : state_r;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      state_r   <= CBD_STATE_RESET;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
      state_r   <= state_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (s2_load) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_res_r.length, out_res_r.data};
  assign out_tuser  = {out_res_r.status, out_res_r.valid};

endmodule

`default_nettype wire

// ===== src/cbd_checker.sv =====
// Port-level checks for the chunked body decoder, bound to the top level.
`default_nettype none

module cbd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic [2:0]  out_tuser
);
  import cbd_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // status is never the unused code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[2:1] == ST_BUSY || out_tuser[2:1] == ST_DONE
                   || out_tuser[2:1] == ST_ERR)
    else $error("bad status code");

  // empty result stage means the input side cannot be blocked
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result stage");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat present after reset");

endmodule

bind chunked_body_decoder_core cbd_checker u_cbd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ===== verif/chunked_body_decoder_core_tb.sv =====
// Self-checking testbench for the chunked body decoder core.
`timescale 1ns / 100ps

module chunked_body_decoder_core_tb;
  import cbd_pkg::*;

  localparam int N_ITEMS      = 950;     // body bytes to push through
  localparam int CYCLE_LIMIT  = 400000;  // watchdog, far above the slowest run
  localparam int DRAIN_CYCLES = 8;       // settle time once nothing is owed
  localparam int HOLD_CYCLES  = 80;      // long receiver hold-off

  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_NINE  = "9";
  localparam logic [7:0] CH_LOW_A = "a";
  localparam logic [7:0] CH_LOW_F = "f";
  localparam logic [7:0] CH_UP_A  = "A";
  localparam logic [7:0] CH_SEMI  = ";";

  // Decoder shadow: mirrors the parse state and queues the result beat
  // that each accepted body byte should produce.
  class decode_tracker;
    logic [2:0]           phase;
    logic [SIZE_BITS-1:0] chunk_size;
    logic [SIZE_BITS-1:0] bytes_left;
    logic                 hex_stopped;
    logic                 saw_cr;
    logic                 trailer_skipped;
    logic [LEN_BITS-1:0]  total_out;
    cbd_result_t          decoded_due[$];
    int errors, n_checked, n_payload, n_done, n_err;

    function new();
      errors = 0; n_checked = 0; n_payload = 0; n_done = 0; n_err = 0;
      restart();
    endfunction

    function void restart();
      phase           = PH_SIZE;
      chunk_size      = '0;
      bytes_left      = '0;
      hex_stopped     = 1'b0;
      saw_cr          = 1'b0;
      trailer_skipped = 1'b0;
      total_out       = '0;
    endfunction

    // Bit 4 set: not a hex digit. Letters are folded to lower case first.
    function logic [4:0] digit_of(logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return {1'b0, c[3:0]};
      if ((c | 8'h20) >= CH_LOW_A && (c | 8'h20) <= CH_LOW_F)
        return {1'b0, c[3:0] + 4'd9};
      return 5'h10;
    endfunction

    function int pending();
      return decoded_due.size();
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      cbd_result_t r;
      logic [4:0]  dig;
      logic        boundary;
      r = '0;
      boundary = 1'b0;
      case (phase)
        PH_SIZE: begin
          if (saw_cr && b == BYTE_LF) begin
            if (chunk_size == '0) begin
              phase = PH_DONE;
            end else begin
              bytes_left = chunk_size;
              phase = PH_DATA;
            end
            saw_cr = 1'b0;
          end else begin
            if (!hex_stopped) begin
              dig = digit_of(b);
              if (!dig[4]) begin
                // a further digit would not fit: error straight away
                if (chunk_size[SIZE_BITS-1 -: 4] != 4'd0) phase = PH_ERR;
                else chunk_size = {chunk_size[SIZE_BITS-5:0], dig[3:0]};
              end else begin
                hex_stopped = 1'b1;
              end
            end
            if (phase != PH_ERR) saw_cr = (b == BYTE_CR);
          end
        end
        PH_DATA: begin
          r.data  = b;
          r.valid = 1'b1;
          if (total_out != '1) total_out = total_out + 1'b1;
          bytes_left = bytes_left - 1'b1;
          if (bytes_left == '0) begin
            phase = PH_TRAIL;
            trailer_skipped = 1'b0;
          end
        end
        PH_TRAIL: begin
          if (!trailer_skipped) begin
            trailer_skipped = 1'b1;
          end else begin
            phase           = PH_SIZE;
            chunk_size      = '0;
            hex_stopped     = 1'b0;
            saw_cr          = 1'b0;
            trailer_skipped = 1'b0;
            boundary        = 1'b1;
          end
        end
        PH_DONE: ;
        default: phase = PH_ERR;
      endcase

      if (phase == PH_DONE || (last && boundary)) r.status = ST_DONE;
      else if (phase == PH_ERR || last)          r.status = ST_ERR;
      else                                        r.status = ST_BUSY;
      r.length = total_out;
      decoded_due.push_back(r);
      if (last) restart();
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("MISMATCH at result %0d: %s", n_checked, what);
    endtask

    task match_result(logic [39:0] td, logic [2:0] tu);
      cbd_result_t want;
      if (decoded_due.size() == 0) begin
        report_mismatch("result beat with nothing outstanding");
        return;
      end
      want = decoded_due.pop_front();
      n_checked++;
      if (want.valid) n_payload++;
      if (want.status == ST_DONE) n_done++;
      if (want.status == ST_ERR) n_err++;
      if (tu[0] !== want.valid)
        report_mismatch($sformatf("valid %b, want %b", tu[0], want.valid));
      if (td[7:0] !== want.data)
        report_mismatch($sformatf("byte %h, want %h", td[7:0], want.data));
      if (tu[2:1] !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", tu[2:1], want.status));
      if (td[39:8] !== want.length)
        report_mismatch($sformatf("length %0d, want %0d", td[39:8], want.length));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] in_byte
  logic        in_tlast;   // is_last
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [7:0] out_byte, [39:8] decoded_length
  logic [2:0]  out_tuser;  // [0] out_valid, [2:1] status

  decode_tracker tracker;
  logic [7:0]    body_bytes[$];   // body under construction, last byte last
  int cycle_count  = 0;
  int bytes_sent   = 0;
  int bodies_sent  = 0;
  int burst_left   = 0;
  int no_gap_left  = 0;
  int squeeze_req  = 0;           // bumped by stimulus, watched by receiver
  int held_cycles  = 0;           // input offered but refused

  chunked_body_decoder_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Handshake monitor. Values read here are the ones the edge sampled, as
  // the DUT's own updates land later in the time step.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) tracker.match_result(out_tdata, out_tuser);
      if (in_tvalid && in_tready) tracker.take_byte(in_tdata, in_tlast);
      if (in_tvalid && !in_tready) held_cycles++;
    end
  end

  // Receiver: switches at random between stall styles (always ready, coin
  // toss, rotating pattern, mostly stalled), plus a long hold-off whenever
  // the stimulus asks for one so that both stages fill and in_tready drops.
  initial begin : receiver
    int         hold_left;
    int         mode;
    int         mode_left;
    int         seen_req;
    logic [7:0] pat;
    hold_left = 0; mode = 0; mode_left = 0; seen_req = 0; pat = '1;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_req != seen_req) begin
        seen_req  = squeeze_req;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 96);
        pat       = 8'($urandom);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: begin
            out_tready <= pat[0];
            pat = {pat[0], pat[7:1]};
          end
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timed out after %0d cycles with %0d results outstanding",
             CYCLE_LIMIT, tracker.pending());
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [7:0] hex_char(logic [3:0] v, bit upper);
    if (v < 4'd10) return CH_ZERO + 8'(v);
    if (upper) return CH_UP_A + 8'(v) - 8'd10;
    return CH_LOW_A + 8'(v) - 8'd10;
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) body_bytes.push_back(s[i]);
  endfunction

  // Optional extension (hex already stopped by the ';'), the odd lone CR,
  // then the CR LF that closes the line.
  function automatic void put_line_tail();
    logic [7:0] b;
    if ($urandom_range(0, 3) == 0) begin
      body_bytes.push_back(CH_SEMI);
      repeat ($urandom_range(0, 5)) begin
        b = 8'($urandom_range(0, 255));
        if (b == BYTE_CR) b = BYTE_LF;   // lone LF must not end the line
        body_bytes.push_back(b);
      end
    end
    if ($urandom_range(0, 7) == 0) begin
      body_bytes.push_back(BYTE_CR);
      body_bytes.push_back(CH_SEMI);
    end
    body_bytes.push_back(BYTE_CR);
    body_bytes.push_back(BYTE_LF);
  endfunction

  function automatic void put_size_line(logic [31:0] v, bit with_digits);
    int nd;
    bit up;
    up = 1'($urandom_range(0, 1));
    if (with_digits) begin
      nd = 1;
      for (int k = 1; k < 8; k++) if ((v >> (4 * k)) != 0) nd = k + 1;
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 2)) body_bytes.push_back(CH_ZERO);
      for (int k = nd - 1; k >= 0; k--) body_bytes.push_back(hex_char(v[4*k +: 4], up));
    end
    put_line_tail();
  endfunction

  // Mostly well-formed bodies with random content; the rest end on a bare
  // chunk boundary, carry an over-wide size, get cut short, or are noise.
  function automatic void build_random_body();
    int kind;
    int nchunks;
    int sz;
    int cut;
    body_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind < 6) begin
      repeat ($urandom_range(1, 10)) body_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    nchunks = $urandom_range(0, 3);
    if (kind >= 70 && kind < 78 && nchunks == 0) nchunks = 1;
    repeat (nchunks) begin
      sz = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
      put_size_line(sz, 1'b1);
      repeat (sz) body_bytes.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) == 0) begin
        // bytes after the data are skipped whatever they hold
        body_bytes.push_back(8'($urandom_range(0, 255)));
        body_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        body_bytes.push_back(BYTE_CR);
        body_bytes.push_back(BYTE_LF);
      end
    end
    if (kind < 70) begin
      put_size_line(0, $urandom_range(0, 4) != 0);
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) body_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 78) begin
      // ends cleanly after a chunk's trailing pair, no zero line
    end else if (kind < 88) begin
      body_bytes.push_back(hex_char(4'($urandom_range(1, 15)), 1'($urandom_range(0, 1))));
      repeat ($urandom_range(8, 9))
        body_bytes.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
      repeat ($urandom_range(0, 2)) body_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      put_size_line(0, 1'b1);
      cut = $urandom_range(1, body_bytes.size());
      while (body_bytes.size() > cut) void'(body_bytes.pop_back());
    end
  endfunction

  // Sends body_bytes in bursts of random length with random gaps between
  // them; tlast goes on the final byte. Waits on the handshake per beat.
  task automatic send_body();
    int gap;
    for (int i = 0; i < body_bytes.size(); i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if (no_gap_left == 0) begin
          gap = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
          if (gap > 0) begin
            in_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
      end
      burst_left--;
      if (no_gap_left > 0) no_gap_left--;
      in_tvalid <= 1'b1;
      in_tdata  <= body_bytes[i];
      in_tlast  <= (i == body_bytes.size() - 1);
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      bytes_sent++;
    end
    bodies_sent++;
  endtask

  initial begin : stimulus
    int squeezes;
    squeezes = 0;
    tracker = new();
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // One-byte chunk of 0xFF; last on the second skipped byte, so the body
    // completes at a chunk boundary.
    body_bytes.delete();
    add_text("1\r\n");
    body_bytes.push_back(8'hFF);
    add_text("\r\n");
    send_body();
    // Zero size with a lone CR and a lone LF before the real line end,
    // then a 0x00 that is ignored after completion.
    body_bytes.delete();
    add_text("0\r;\n\r\n");
    body_bytes.push_back(8'h00);
    send_body();
    // Nine digits overflow the size register; the next byte is ignored.
    body_bytes.delete();
    add_text("123456789x");
    send_body();
    // No leading hex digit at all: size zero, body done on the LF.
    body_bytes.delete();
    add_text("\r\n");
    send_body();

    while (bytes_sent < N_ITEMS) begin
      // twice in the run: stall the receiver and offer beats back to back
      if (squeezes < 2 && bytes_sent >= 300 + 350 * squeezes) begin
        squeezes++;
        squeeze_req <= squeeze_req + 1;
        no_gap_left = 60;
      end
      build_random_body();
      send_body();
    end
    in_tvalid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Decoded %0d bodies from %0d bytes; %0d result beats checked, %0d payload.",
             bodies_sent, bytes_sent, tracker.n_checked, tracker.n_payload);
    $display("Status done on %0d beats, error on %0d; input refused for %0d cycles.",
             tracker.n_done, tracker.n_err, held_cycles);
    if (tracker.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", tracker.errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== chunked_body_decoder_core.f =====
src/cbd_pkg.sv
src/cbd_step.sv
src/chunked_body_decoder_core.sv
src/cbd_checker.sv
verif/chunked_body_decoder_core_tb.sv
